>>> design/pcfd_pkg.sv
`timescale 1ns / 1ps

package pcfd_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned ErrWidth    = 17;
  localparam int unsigned GainWidth   = 24;
  localparam int unsigned PoleWidth   = 18;
  localparam int unsigned StateWidth  = 32;
  localparam int unsigned IdxWidth    = 4;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned PropWidth   = 41;
  localparam int unsigned IncWidth    = 42;
  localparam int unsigned DerivWidth  = 41;

  typedef enum logic [IdxWidth-1:0] {
    REG_PROP_GAIN       = 4'd0,
    REG_INTEGRAL_GAIN   = 4'd1,
    REG_DERIVATIVE_GAIN = 4'd2,
    REG_DERIVATIVE_POLE = 4'd3,
    REG_INTEGRAL_UPPER  = 4'd4,
    REG_INTEGRAL_LOWER  = 4'd5,
    REG_DRIVE_UPPER     = 4'd6,
    REG_DRIVE_LOWER     = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [GainWidth-1:0]   prop_gain;
    logic signed [GainWidth-1:0]   integral_gain;
    logic signed [GainWidth-1:0]   derivative_gain;
    logic signed [PoleWidth-1:0]   derivative_pole;
    logic signed [StateWidth-1:0]  integral_upper;
    logic signed [StateWidth-1:0]  integral_lower;
    logic signed [SampleWidth-1:0] drive_upper;
    logic signed [SampleWidth-1:0] drive_lower;
  } cfg_t;

  // Products of the gains with terms that depend only on the sample and the previous sample.
  typedef struct packed {
    logic signed [PropWidth-1:0]  p;
    logic signed [IncWidth-1:0]   iinc;
    logic signed [DerivWidth-1:0] dinc;
  } front_t;

endpackage

>>> design/pcfd_in_if.sv
`timescale 1ns / 1ps

interface pcfd_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] measure;
  logic signed [15:0] target;

  modport source (output valid, output measure, output target, input ready);
  modport sink (input valid, input measure, input target, output ready);
endinterface

>>> design/pcfd_out_if.sv
`timescale 1ns / 1ps

interface pcfd_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

>>> design/pcfd_cfg_if.sv
`timescale 1ns / 1ps

interface pcfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/pcfd_regs.sv
`timescale 1ns / 1ps

module pcfd_regs import pcfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [IdxWidth-1:0]  index,
  input  logic [DataWidth-1:0] data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        REG_PROP_GAIN:       cfg_nxt.prop_gain       = signed'(data[GainWidth-1:0]);
        REG_INTEGRAL_GAIN:   cfg_nxt.integral_gain   = signed'(data[GainWidth-1:0]);
        REG_DERIVATIVE_GAIN: cfg_nxt.derivative_gain = signed'(data[GainWidth-1:0]);
        REG_DERIVATIVE_POLE: cfg_nxt.derivative_pole = signed'(data[PoleWidth-1:0]);
        REG_INTEGRAL_UPPER:  cfg_nxt.integral_upper  = signed'(data[StateWidth-1:0]);
        REG_INTEGRAL_LOWER:  cfg_nxt.integral_lower  = signed'(data[StateWidth-1:0]);
        REG_DRIVE_UPPER:     cfg_nxt.drive_upper     = signed'(data[SampleWidth-1:0]);
        REG_DRIVE_LOWER:     cfg_nxt.drive_lower     = signed'(data[SampleWidth-1:0]);
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= '0;
      cfg_r.integral_gain   <= '0;
      cfg_r.derivative_gain <= '0;
      cfg_r.derivative_pole <= '0;
      cfg_r.integral_upper  <= 32'sh7FFF_FFFF;
      cfg_r.integral_lower  <= 32'sh8000_0000;
      cfg_r.drive_upper     <= 16'sh7FFF;
      cfg_r.drive_lower     <= 16'sh8000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/pcfd_front.sv
`timescale 1ns / 1ps

module pcfd_front import pcfd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          take,
  input  logic signed [SampleWidth-1:0] measure,
  input  logic signed [SampleWidth-1:0] target,
  input  logic                          adv,
  output logic                          valid,
  output front_t                        data
);

  logic signed [ErrWidth-1:0]    last_err_r;
  logic signed [SampleWidth-1:0] last_meas_r;
  logic                          valid_r;
  logic                          valid_nxt;
  front_t                        data_r;
  front_t                        data_nxt;

  logic signed [ErrWidth-1:0]   err;
  logic signed [ErrWidth:0]     err_sum;
  logic signed [ErrWidth-1:0]   dmeas;

  assign err     = ErrWidth'(target) - ErrWidth'(measure);
  assign err_sum = (ErrWidth + 1)'(err) + (ErrWidth + 1)'(last_err_r);
  assign dmeas   = ErrWidth'(measure) - ErrWidth'(last_meas_r);

  always_comb begin
    data_nxt.p    = PropWidth'(cfg.prop_gain) * PropWidth'(err);
    data_nxt.iinc = IncWidth'(cfg.integral_gain) * IncWidth'(err_sum);
    data_nxt.dinc = DerivWidth'(cfg.derivative_gain) * DerivWidth'(dmeas);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      last_err_r  <= '0;
      last_meas_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        last_err_r  <= err;
        last_meas_r <= measure;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

>>> design/pcfd_core.sv
`timescale 1ns / 1ps

module pcfd_core import pcfd_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           in_valid,
  input  front_t                         in_data,
  input  logic                           out_ready,
  output logic                           adv,
  output logic                           out_valid,
  output logic signed [SampleWidth-1:0]  drive
);

  localparam int unsigned WideWidth = 48;
  localparam int unsigned ProdWidth = PoleWidth + StateWidth;
  localparam int unsigned SumWidth  = 42;
  localparam int unsigned QuotWidth = SumWidth - 16;

  function automatic logic signed [StateWidth-1:0] sat32(input logic signed [WideWidth-1:0] x);
    logic signed [WideWidth-1:0] hi;
    logic signed [WideWidth-1:0] lo;
    hi = WideWidth'(32'sh7FFF_FFFF);
    lo = WideWidth'(32'sh8000_0000);
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[StateWidth-1:0];
    end
  endfunction

  logic signed [StateWidth-1:0]  acc_r;
  logic signed [StateWidth-1:0]  acc_nxt;
  logic signed [StateWidth-1:0]  filt_r;
  logic signed [StateWidth-1:0]  filt_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [SampleWidth-1:0] drive_r;
  logic signed [SampleWidth-1:0] drive_nxt;

  logic signed [StateWidth-1:0]  i_sat;
  logic signed [ProdWidth-1:0]   pole_prod;
  logic signed [ProdWidth-17:0]  pole_floor;
  logic signed [SumWidth-1:0]    sum;
  logic signed [SumWidth-1:0]    hi;
  logic signed [SumWidth-1:0]    lo;
  logic signed [SumWidth-1:0]    sum_c;
  logic signed [QuotWidth-1:0]   quot;
  logic                          round_up;

  assign adv = in_valid && (!out_valid_r || out_ready);

  assign i_sat = sat32(WideWidth'(acc_r) + WideWidth'(in_data.iinc));

  always_comb begin
    if (i_sat > cfg.integral_upper) begin
      acc_nxt = cfg.integral_upper;
    end else if (i_sat < cfg.integral_lower) begin
      acc_nxt = cfg.integral_lower;
    end else begin
      acc_nxt = i_sat;
    end
  end

  // The arithmetic shift of the pole product floors toward minus infinity.
  assign pole_prod  = ProdWidth'(cfg.derivative_pole) * ProdWidth'(filt_r);
  assign pole_floor = signed'(pole_prod[ProdWidth-1:16]);
  assign filt_nxt   = sat32(WideWidth'(in_data.dinc) + WideWidth'(pole_floor));

  assign sum = SumWidth'(in_data.p) + SumWidth'(acc_nxt) + SumWidth'(filt_nxt);
  assign hi  = SumWidth'(cfg.drive_upper) <<< 16;
  assign lo  = SumWidth'(cfg.drive_lower) <<< 16;

  always_comb begin
    if (sum > hi) begin
      sum_c = hi;
    end else if (sum < lo) begin
      sum_c = lo;
    end else begin
      sum_c = sum;
    end
  end

  // Truncation toward zero: a negative value with a fraction moves up by one.
  assign round_up  = sum_c[SumWidth-1] && (sum_c[15:0] != 16'h0);
  assign quot      = signed'(sum_c[SumWidth-1:16]) + QuotWidth'(round_up);
  assign drive_nxt = quot[SampleWidth-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        acc_r  <= acc_nxt;
        filt_r <= filt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign drive     = drive_r;

endmodule

>>> design/pid_controller_filtered_derivative.sv
`timescale 1ns / 1ps

// Discrete PID controller with a trapezoidal integral and a low-pass filtered
// derivative on the measurement, in Q16.16 fixed point. Each input item is one
// sample (measure, target) and gives one drive item, clamped to the drive
// limits and truncated toward zero. The block takes one item per clock cycle
// while the output is not stalled. The error products are formed ahead of the
// input register. The core closes the integral and filter recurrences, and
// their update through the pole multiplier sets the rate. A result passes the
// input register and then the output register. While a result waits in the
// output register, one more item is taken into the input register, and after
// that the input stalls. The user must write configuration registers only
// while no item is in flight; the block itself does not enforce this.

module pid_controller_filtered_derivative import pcfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pcfd_in_if.sink   in_chan,
  pcfd_out_if.source out_chan,
  pcfd_cfg_if.sink  cfg_chan
);

  cfg_t   cfg;
  front_t s1_data;
  logic   s1_valid;
  logic   adv;
  logic   take;
  logic   cfg_we;

  assign cfg_chan.ready = 1'b1;
  assign cfg_we         = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready = !s1_valid || adv;
  assign take          = in_chan.valid && in_chan.ready;

  pcfd_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_chan.index),
    .data  (cfg_chan.data),
    .cfg   (cfg)
  );

  pcfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .take    (take),
    .measure (in_chan.measure),
    .target  (in_chan.target),
    .adv     (adv),
    .valid   (s1_valid),
    .data    (s1_data)
  );

  pcfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_ready (out_chan.ready),
    .adv       (adv),
    .out_valid (out_chan.valid),
    .drive     (out_chan.drive)
  );

`ifndef SYNTH
  a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_chan.valid && !out_chan.ready) |=> s1_valid)
    else $error("stage item lost while output stalled");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(s1_valid))
    else $error("result appeared without a staged item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_chan.valid && !s1_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pcfd_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int RandomPhases = 12;
  localparam int PhaseSamples = 137;
  localparam logic [IdxWidth-1:0] UnusedIndexLow = 4'd8;
  localparam logic [IdxWidth-1:0] UnusedIndexHigh = 4'd15;

  typedef struct packed {
    logic signed [SampleWidth-1:0] measure;
    logic signed [SampleWidth-1:0] target;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pcfd_in_if in_if ();
  pcfd_out_if out_if ();
  pcfd_cfg_if cfg_if ();

  pid_controller_filtered_derivative uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #6 clk = ~clk;

  // Shadow copy of the controller's settings and recurrence state.
  cfg_t gains = '{
    prop_gain: '0, integral_gain: '0, derivative_gain: '0, derivative_pole: '0,
    integral_upper: 32'sh7FFFFFFF, integral_lower: 32'sh80000000,
    drive_upper: 16'sh7FFF, drive_lower: 16'sh8000
  };
  logic signed [StateWidth-1:0] integ_acc = '0;
  logic signed [StateWidth-1:0] filt_deriv = '0;
  logic signed [ErrWidth-1:0] prev_err = '0;
  logic signed [SampleWidth-1:0] prev_meas = '0;

  sample_t sample_queue[$];
  logic signed [SampleWidth-1:0] drive_expected[$];
  int items_queued = 0;
  int results_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [SampleWidth-1:0] predict_drive(
      input logic signed [SampleWidth-1:0] meas, input logic signed [SampleWidth-1:0] targ);
    longint err, prop, integ, deriv, total, hi, lo;
    err = longint'(targ) - longint'(meas);
    prop = longint'(gains.prop_gain) * err;
    integ = clip32(longint'(integ_acc) + longint'(gains.integral_gain) * (err + longint'(prev_err)));
    if (integ > longint'(gains.integral_upper)) begin
      integ = longint'(gains.integral_upper);
    end else if (integ < longint'(gains.integral_lower)) begin
      integ = longint'(gains.integral_lower);
    end
    deriv = longint'(gains.derivative_gain) * (longint'(meas) - longint'(prev_meas))
          + ((longint'(gains.derivative_pole) * longint'(filt_deriv)) >>> 16);
    deriv = clip32(deriv);
    integ_acc = integ[31:0];
    filt_deriv = deriv[31:0];
    total = prop + integ + deriv;
    hi = longint'(gains.drive_upper) * 65536;
    lo = longint'(gains.drive_lower) * 65536;
    if (total > hi) begin
      total = hi;
    end else if (total < lo) begin
      total = lo;
    end
    prev_err = err[ErrWidth-1:0];
    prev_meas = meas;
    return 16'(total / 65536);
  endfunction

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("tb_top: %s", msg);
    end
  endfunction

  function automatic int pick_idle(input bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Sample driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        drive_expected.push_back(predict_drive(in_if.measure, in_if.target));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_if.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_if.measure <= sample_queue[0].measure;
          in_if.target <= sample_queue[0].target;
          void'(sample_queue.pop_front());
          in_if.valid <= 1'b1;
          send_wait <= pick_idle(send_idle_on);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Drive monitor and receiver stalls.
  always @(posedge clk) begin
    logic signed [SampleWidth-1:0] want;
    int stall;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (drive_expected.size() == 0) begin
          note_fail($sformatf("drive %0d arrived with nothing expected", out_if.drive));
        end else begin
          want = drive_expected.pop_front();
          if (out_if.drive !== want) begin
            note_fail($sformatf("drive mismatch on result %0d: expected %0d, got %0d",
                                results_checked, want, out_if.drive));
          end
          results_checked <= results_checked + 1;
        end
      end
      if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_if.ready <= 1'b0;
      end else begin
        stall = pick_idle(recv_idle_on);
        out_if.ready <= (stall == 0);
        recv_wait <= (stall > 0) ? stall - 1 : 0;
      end
    end
  end

  task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [DataWidth-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PROP_GAIN:       gains.prop_gain = data[GainWidth-1:0];
      REG_INTEGRAL_GAIN:   gains.integral_gain = data[GainWidth-1:0];
      REG_DERIVATIVE_GAIN: gains.derivative_gain = data[GainWidth-1:0];
      REG_DERIVATIVE_POLE: gains.derivative_pole = data[PoleWidth-1:0];
      REG_INTEGRAL_UPPER:  gains.integral_upper = data;
      REG_INTEGRAL_LOWER:  gains.integral_lower = data;
      REG_DRIVE_UPPER:     gains.drive_upper = data[SampleWidth-1:0];
      REG_DRIVE_LOWER:     gains.drive_lower = data[SampleWidth-1:0];
      default: ;
    endcase
  endtask

  // Bits above a field's width are don't-care, so they get random junk.
  function automatic logic [DataWidth-1:0] with_junk(input longint v, input int w);
    logic [DataWidth-1:0] mask;
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 1);
    return (32'($urandom) & ~mask) | (32'(v) & mask);
  endfunction

  task automatic write_settings(input cfg_t s);
    write_reg(REG_PROP_GAIN, with_junk(s.prop_gain, GainWidth));
    write_reg(REG_INTEGRAL_GAIN, with_junk(s.integral_gain, GainWidth));
    write_reg(REG_DERIVATIVE_GAIN, with_junk(s.derivative_gain, GainWidth));
    write_reg(REG_DERIVATIVE_POLE, with_junk(s.derivative_pole, PoleWidth));
    write_reg(REG_INTEGRAL_UPPER, s.integral_upper);
    write_reg(REG_INTEGRAL_LOWER, s.integral_lower);
    write_reg(REG_DRIVE_UPPER, with_junk(s.drive_upper, SampleWidth));
    write_reg(REG_DRIVE_LOWER, with_junk(s.drive_lower, SampleWidth));
  endtask

  function automatic logic signed [GainWidth-1:0] random_gain();
    int mag;
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      default: begin
        mag = $urandom_range(0, 1 << $urandom_range(4, 22));
        return $urandom_range(0, 1) ? -$signed(24'(mag)) : $signed(24'(mag));
      end
    endcase
  endfunction

  function automatic logic signed [PoleWidth-1:0] random_pole();
    int p;
    case ($urandom_range(0, 9))
      0: p = 65536;
      1: p = -65536;
      2: p = 0;
      3: p = $urandom;
      4: p = -$urandom_range(0, 65536);
      default: p = $urandom_range(0, 65536);
    endcase
    return 18'(p);
  endfunction

  function automatic void random_limits(input int w, output longint hi, output longint lo);
    longint top, a, b;
    top = (longint'(1) << (w - 1)) - 1;
    a = longint'($signed($urandom)) >>> (32 - w + $urandom_range(0, w - 4));
    b = longint'($signed($urandom)) >>> (32 - w + $urandom_range(0, w - 4));
    case ($urandom_range(0, 5))
      0: begin
        hi = top;
        lo = -top - 1;
      end
      1: begin
        hi = (a < b) ? a : b;
        lo = (a < b) ? b : a;
      end
      2: begin
        hi = a;
        lo = a;
      end
      default: begin
        hi = (a < b) ? b : a;
        lo = (a < b) ? a : b;
      end
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    longint hi, lo;
    s.prop_gain = random_gain();
    s.integral_gain = random_gain();
    s.derivative_gain = random_gain();
    s.derivative_pole = random_pole();
    random_limits(32, hi, lo);
    s.integral_upper = 32'(hi);
    s.integral_lower = 32'(lo);
    random_limits(16, hi, lo);
    s.drive_upper = 16'(hi);
    s.drive_lower = 16'(lo);
    return s;
  endfunction

  task automatic queue_sample(input int m, input int t);
    sample_queue.push_back('{measure: 16'(m), target: 16'(t)});
    items_queued++;
  endtask

  task automatic wait_drained();
    while (results_checked != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic queue_walk(input int count, inout int m, inout int t, input int span);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_sample($signed(16'($urandom)), $signed(16'($urandom)));
      end else begin
        m = clamp16(m + $urandom_range(0, 2 * span) - span);
        if ($urandom_range(0, 99) < 5) begin
          t = $signed(16'($urandom));
        end
        queue_sample(m, t);
      end
    end
  endtask

  initial begin
    cfg_t s;
    int walk_m, walk_t, span;
    in_if.valid = 1'b0;
    in_if.measure = '0;
    in_if.target = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    s = '{prop_gain: 24'sd65536, integral_gain: 24'sd6554, derivative_gain: -24'sd32768,
          derivative_pole: 18'sd32768, integral_upper: 32'sd65536000,
          integral_lower: -32'sd65536000, drive_upper: 16'sd30000, drive_lower: -16'sd30000};
    write_settings(s);
    write_reg(UnusedIndexLow, $urandom);
    write_reg(UnusedIndexHigh, $urandom);
    recv_idle_on = 1'b1;
    queue_sample(0, 0);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, 32767);
    queue_sample(0, 32767);
    queue_sample(0, -32768);
    queue_sample(100, 200);
    queue_sample(100, 200);
    queue_sample(-1, 0);
    queue_sample(1, -1);
    wait_drained();

    // Saturating gains, a pole beyond one and inverted limits on both clamps.
    s = '{prop_gain: 24'sh7FFFFF, integral_gain: 24'sh7FFFFF, derivative_gain: 24'sh800000,
          derivative_pole: 18'sh1FFFF, integral_upper: -32'sd327680,
          integral_lower: 32'sd327680, drive_upper: -16'sd100, drive_lower: 16'sd100};
    write_settings(s);
    send_idle_on = 1'b1;
    for (int k = 0; k < 4; k++) begin
      queue_sample(-32768, 32767);
      queue_sample(32767, -32768);
    end
    wait_drained();

    s = '{prop_gain: 24'sh800000, integral_gain: 24'sh800000, derivative_gain: 24'sh7FFFFF,
          derivative_pole: 18'sh20000, integral_upper: 32'sh7FFFFFFF,
          integral_lower: 32'sh80000000, drive_upper: 16'sh7FFF, drive_lower: 16'sh8000};
    write_settings(s);
    for (int k = 0; k < 3; k++) begin
      queue_sample(32767, -32768);
      queue_sample(-32768, 32767);
    end
    wait_drained();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      write_settings(random_settings());
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: span = 4;
        1: span = 64;
        default: span = 2048;
      endcase
      walk_m = $signed(16'($urandom));
      walk_t = $signed(16'($urandom));
      queue_walk(PhaseSamples / 2, walk_m, walk_t, span);
      if (phase % 2 == 1) begin
        wait_drained();
      end
      queue_walk(PhaseSamples - PhaseSamples / 2, walk_m, walk_t, span);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (drive_expected.size() != 0) begin
      note_fail($sformatf("%0d expected drive values never arrived", drive_expected.size()));
    end
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pcfd_pkg.sv
design/pcfd_in_if.sv
design/pcfd_out_if.sv
design/pcfd_cfg_if.sv
design/pcfd_regs.sv
design/pcfd_front.sv
design/pcfd_core.sv
design/pid_controller_filtered_derivative.sv
bench/tb_top.sv
